>>> rtl/fccw_pkg.sv
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types and constants for the FAT12 cluster chain walker: item kinds,
// walker states, register offsets, register reset values and the FAT12 entry constants.
// ----------------------------------------------------------------------------
package fccw_pkg;

    // Kind of an input transaction, carried in s_tuser.
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_CONT  = 2'd2
    } kind_t;

    // Walker sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } walk_state_t;

    // Register select bit of the configuration port (paddr[2]).
    localparam logic REG_DATA_START = 1'b0;
    localparam logic REG_SEC_PER_CL = 1'b1;

    // FAT12 entry constants.
    localparam logic [11:0] CLUSTER_MASK = 12'hFFF;
    localparam logic [11:0] END_MARK     = 12'hFF8;

    // Reset values of the configuration registers.
    localparam logic [15:0] DATA_START_RST = 16'd33;
    localparam logic [7:0]  SEC_PER_CL_RST = 8'd1;

endpackage

>>> rtl/fat12_cluster_chain_walker.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Holds a FAT12 allocation table and walks cluster chains through it,
// emitting one cluster number and sector address per cluster visited.
// ----------------------------------------------------------------------------
// A load transaction writes one table byte. A start or continue transaction
// is accepted in the idle state and then produces up to MAX_RUN results, one
// cluster at a time: per cluster, the read state issues the read to the table
// memory and the evaluate state evaluates the returned FAT entry and loads the
// output register, waiting there while the output register is full. The
// table is held in two byte banks (even and odd addresses), so both bytes of a
// 12-bit entry come back from one read. The table needs no clearing after
// reset; entries must be loaded before a walk reads them. A result is marked
// with tlast when it ends a run, and tuser is set when the chain itself ended
// there rather than the run limit. Configuration may be written only while
// the walker is idle.
module fat12_cluster_chain_walker
    import fccw_pkg::*;
#(
    parameter int FAT_BYTES = 8192,
    parameter int MAX_RUN   = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // fat_address[12:0], fat_byte[20:13],
                                   // start_cluster[32:21], zero fill [39:33]
    input  logic [1:0]  s_tuser,   // kind[1:0]

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cluster[11:0], sector_address[43:12],
                                   // zero fill [47:44]
    output logic        m_tuser,   // chain_done[0]
    output logic        m_tlast,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BANK_DEPTH = (FAT_BYTES + 1) / 2;
    localparam int BW         = $clog2(BANK_DEPTH);
    localparam int CW         = $clog2(MAX_RUN + 1);

    // Input field unpacking.
    logic [12:0] fat_address;
    logic [7:0]  fat_byte;
    logic [11:0] start_cluster;
    kind_t       kind;

    assign fat_address   = s_tdata[12:0];
    assign fat_byte      = s_tdata[20:13];
    assign start_cluster = s_tdata[32:21];
    assign kind          = kind_t'(s_tuser);

    // Registers.
    walk_state_t      state_reg, state_next;
    logic [15:0]      data_start_reg;
    logic [7:0]       sec_per_cl_reg;
    logic [11:0]      cur_cluster_reg, cur_cluster_next;
    logic [31:0]      lba_reg;
    logic [CW-1:0]    run_cnt_reg, run_cnt_next;
    logic [11:0]      resume_cluster_reg, resume_cluster_next;
    logic             walk_pending_reg, walk_pending_next;
    logic             out_valid_reg, out_valid_next;
    logic [11:0]      out_cluster_reg;
    logic [31:0]      out_lba_reg;
    logic             out_last_reg;
    logic             out_done_reg;

    // Table memory: two byte banks, even and odd table addresses.
    logic [7:0]       even_mem [BANK_DEPTH];
    logic [7:0]       odd_mem  [BANK_DEPTH];
    logic [7:0]       even_rdata_reg;
    logic [7:0]       odd_rdata_reg;

    // Control decode.
    logic             in_xact;
    logic             load_wr;
    logic             walk_go;
    logic             rd_en;
    logic             out_free;
    logic             out_load;

    // Entry address arithmetic for the current cluster.
    logic [12:0]      entry_at;
    logic [11:0]      entry_idx;
    logic [BW-1:0]    even_raddr;
    logic [BW-1:0]    odd_raddr;
    logic [BW-1:0]    waddr;
    logic [15:0]      entry_word;
    logic [11:0]      next_cluster;
    logic             end_hit;
    logic             run_full;

    // Sector address arithmetic.
    logic signed [12:0] cl_offset;
    logic signed [21:0] sec_offset;
    logic [31:0]        lba_calc;

    assign in_xact = s_tvalid && s_tready;

    // Byte offset of the entry is cluster*3/2; both bytes come from one row pair.
    assign entry_at   = {1'b0, cur_cluster_reg} + {2'b00, cur_cluster_reg[11:1]};
    assign entry_idx  = entry_at[12:1];
    assign odd_raddr  = BW'(entry_idx);
    assign even_raddr = entry_at[0] ? BW'(entry_idx + 12'd1) : BW'(entry_idx);
    assign waddr      = BW'(fat_address[12:1]);

    // Load writes, ignored beyond the table size.
    assign load_wr = in_xact && (kind == KIND_LOAD) &&
                     ({19'd0, fat_address} < FAT_BYTES);

    always_ff @(posedge clk)
    begin
        if (load_wr && !fat_address[0])
        begin
            even_mem[waddr] <= fat_byte;
        end
        if (rd_en)
        begin
            even_rdata_reg <= even_mem[even_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr && fat_address[0])
        begin
            odd_mem[waddr] <= fat_byte;
        end
        if (rd_en)
        begin
            odd_rdata_reg <= odd_mem[odd_raddr];
        end
    end

    // Reassemble the little-endian word and pick the 12-bit entry.
    assign entry_word   = entry_at[0] ? {even_rdata_reg, odd_rdata_reg}
                                      : {odd_rdata_reg, even_rdata_reg};
    assign next_cluster = cur_cluster_reg[0] ? entry_word[15:4]
                                             : (entry_word[11:0] & CLUSTER_MASK);
    assign end_hit      = (next_cluster >= END_MARK);
    assign run_full     = (run_cnt_reg == CW'(MAX_RUN - 1));

    // Sector address: data start plus signed cluster offset times cluster size.
    assign cl_offset  = $signed({1'b0, cur_cluster_reg}) - 13'sd2;
    assign sec_offset = 22'(cl_offset) * 22'($signed({1'b0, sec_per_cl_reg}));
    assign lba_calc   = {16'd0, data_start_reg} + 32'(sec_offset);

    assign out_free = !out_valid_reg || m_tready;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (walk_go)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = (end_hit || run_full) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control of the sequencer.
    always_comb
    begin
        s_tready            = 1'b0;
        walk_go             = 1'b0;
        rd_en               = 1'b0;
        out_load            = 1'b0;
        cur_cluster_next    = cur_cluster_reg;
        run_cnt_next        = run_cnt_reg;
        resume_cluster_next = resume_cluster_reg;
        walk_pending_next   = walk_pending_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (kind)
                        KIND_START:
                        begin
                            walk_go           = 1'b1;
                            cur_cluster_next  = start_cluster;
                            run_cnt_next      = '0;
                            walk_pending_next = 1'b0;
                        end
                        KIND_CONT:
                        begin
                            if (walk_pending_reg)
                            begin
                                walk_go          = 1'b1;
                                cur_cluster_next = resume_cluster_reg;
                                run_cnt_next     = '0;
                            end
                        end
                        default:
                        begin
                            walk_go = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (end_hit)
                    begin
                        walk_pending_next = 1'b0;
                    end
                    else if (run_full)
                    begin
                        resume_cluster_next = next_cluster;
                        walk_pending_next   = 1'b1;
                    end
                    else
                    begin
                        cur_cluster_next = next_cluster;
                        run_cnt_next     = run_cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            run_cnt_reg        <= '0;
            resume_cluster_reg <= '0;
            walk_pending_reg   <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            run_cnt_reg        <= run_cnt_next;
            resume_cluster_reg <= resume_cluster_next;
            walk_pending_reg   <= walk_pending_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Walk datapath and output payload.
    always_ff @(posedge clk)
    begin
        cur_cluster_reg <= cur_cluster_next;
        if (rd_en)
        begin
            lba_reg <= lba_calc;
        end
        if (out_load)
        begin
            out_cluster_reg <= cur_cluster_reg;
            out_lba_reg     <= lba_reg;
            out_last_reg    <= end_hit || run_full;
            out_done_reg    <= end_hit;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= DATA_START_RST;
            sec_per_cl_reg <= SEC_PER_CL_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_DATA_START: data_start_reg <= pwdata[15:0];
                REG_SEC_PER_CL: sec_per_cl_reg <= pwdata[7:0];
                default:        data_start_reg <= data_start_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DATA_START: prdata = {16'd0, data_start_reg};
            REG_SEC_PER_CL: prdata = {24'd0, sec_per_cl_reg};
            default:        prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_lba_reg, out_cluster_reg};
    assign m_tuser  = out_done_reg;
    assign m_tlast  = out_last_reg;

    // A chain end always closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("chain end flagged on a result that does not close the run");

    // The run counter stays below the run limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_cnt_reg < CW'(MAX_RUN))
        else $error("run counter beyond run limit");

    // An accepted start transaction always launches a table read.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xact && (kind == KIND_START) |=> state_reg == ST_READ)
        else $error("start transaction did not launch a walk");

    // A blocked output holds the sequencer in evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) && m_tvalid && !m_tready |=> state_reg == ST_EVAL)
        else $error("sequencer advanced while the output register was full");

endmodule
